// ----- rtl/core/wmn_pkg.sv -----
`default_nettype none
package wmn_pkg;

  typedef enum logic [1:0] {
    MODE_RMS      = 2'd0,
    MODE_VARIANCE = 2'd1,
    MODE_WEIGHT   = 2'd2,
    MODE_UNUSED   = 2'd3
  } map_mode_t;

  typedef enum logic [1:0] {
    REG_MAP_MODE         = 2'd0,
    REG_THRESHOLD_ENABLE = 2'd1,
    REG_THRESHOLD        = 2'd2,
    REG_SCALE_FACTOR     = 2'd3
  } cfg_reg_t;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

endpackage
`default_nettype wire

// ----- rtl/core/weight_map_to_noise.sv -----
`default_nettype none
// Pipeline: input register A, RW = (33 + FRACTION_BITS) / 2 root stages, register M,
// NW = 32 + FRACTION_BITS quotient stages and the output register.
// Throughput: one item per cycle; the whole pipeline holds while a result
// waits at the output, set by the one-bit-per-stage root and divider pipes.
// Reset (synchronous, rst high) empties the pipeline and loads the register
// defaults: RMS mode, threshold off, threshold 0, scale factor 1.0.
module weight_map_to_noise #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] pixel_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      noise_value,
  output logic                    bad_pixel,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam int F     = FRACTION_BITS;
  localparam int RW    = (33 + F) / 2;
  localparam int RAD_W = 2 * RW;
  localparam int NW    = 32 + F;
  localparam int PW    = 65;
  localparam int SB1_W = 33;
  localparam int SB2_W = PW + 2;

  // configuration registers
  wmn_pkg::map_mode_t map_mode;
  logic               threshold_enable;
  logic signed [31:0] threshold;
  logic signed [31:0] scale_factor;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_mode         <= wmn_pkg::MODE_RMS;
      threshold_enable <= 1'b0;
      threshold        <= '0;
      scale_factor     <= 32'(1 << F);
    end else if (cfg_valid) begin
      unique case (wmn_pkg::cfg_reg_t'(cfg_index))
        wmn_pkg::REG_MAP_MODE:         map_mode <= wmn_pkg::map_mode_t'(cfg_data[1:0]);
        wmn_pkg::REG_THRESHOLD_ENABLE: threshold_enable <= cfg_data[0];
        wmn_pkg::REG_THRESHOLD:        threshold <= cfg_data;
        wmn_pkg::REG_SCALE_FACTOR:     scale_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  // stage A: input register, threshold test, radicand
  logic               a_valid;
  logic signed [31:0] a_pix;
  logic               a_bad;
  logic [31:0]        a_mag;
  logic [RAD_W-1:0]   a_rad;
  logic signed [31:0] wt_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
    if (en) begin
      a_pix <= pixel_value;
    end
  end

  always_comb begin
    wt_thr = threshold_enable ? threshold : '0;
    a_mag  = a_pix[31] ? 32'(-a_pix) : 32'(a_pix);
    a_rad  = RAD_W'({a_mag, {F{1'b0}}});
    case (map_mode) inside
      wmn_pkg::MODE_RMS, wmn_pkg::MODE_VARIANCE: a_bad = threshold_enable && !(a_pix < threshold);
      wmn_pkg::MODE_WEIGHT: a_bad = !(a_pix > wt_thr);
      default: a_bad = 1'b1;
    endcase
  end

  logic             s_valid;
  logic [RW-1:0]    s_root;
  logic [SB1_W-1:0] s_side;

  wmn_sqrt #(.RW(RW), .SB_W(SB1_W)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (a_valid),
    .in_rad   (a_rad),
    .in_side  ({a_pix, a_bad}),
    .out_valid(s_valid),
    .out_root (s_root),
    .out_side (s_side)
  );

  // stage M: product and divider operands
  logic signed [31:0] s_pix;
  logic signed [32:0] mul_op;
  logic [31:0]        fac_mag;
  logic               m_valid;
  logic signed [PW-1:0] m_prod;
  logic [NW-1:0]      m_num;
  logic [RW-1:0]      m_den;
  logic               m_bad;
  logic               m_zero;

  always_comb begin
    s_pix   = s_side[SB1_W-1:1];
    mul_op  = (map_mode == wmn_pkg::MODE_VARIANCE) ? $signed(33'(s_root))
                                                   : {s_pix[31], s_pix};
    fac_mag = scale_factor[31] ? 32'(-scale_factor) : 32'(scale_factor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= s_valid;
    end
    if (en) begin
      m_prod <= scale_factor * mul_op;
      m_num  <= {fac_mag, {F{1'b0}}};
      m_den  <= s_root;
      m_bad  <= s_side[0];
      m_zero <= (s_root == '0);
    end
  end

  logic             d_valid;
  logic [NW-1:0]    d_quo;
  logic [SB2_W-1:0] d_side;

  wmn_div #(.NW(NW), .DW(RW), .SB_W(SB2_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (m_valid),
    .in_num   (m_num),
    .in_den   (m_den),
    .in_side  ({m_prod, m_bad, m_zero}),
    .out_valid(d_valid),
    .out_quo  (d_quo),
    .out_side (d_side)
  );

  // final stage: round, saturate, pick by mode
  logic signed [PW-1:0] d_prod;
  logic signed [PW-1:0] rnd;
  logic signed [31:0]   prod_sat;
  logic signed [31:0]   quo_val;
  logic signed [31:0]   f_val;
  logic                 f_bad;

  always_comb begin
    d_prod = d_side[SB2_W-1:2];
    rnd    = (d_prod + PW'(1 << (F - 1))) >>> F;
    if (rnd > PW'(wmn_pkg::SAT_MAX)) begin
      prod_sat = wmn_pkg::SAT_MAX;
    end else if (rnd < PW'(wmn_pkg::SAT_MIN)) begin
      prod_sat = wmn_pkg::SAT_MIN;
    end else begin
      prod_sat = rnd[31:0];
    end
    if (scale_factor[31]) begin
      quo_val = (d_quo > NW'(33'h0_8000_0000)) ? wmn_pkg::SAT_MIN : 32'(-d_quo[31:0]);
    end else begin
      quo_val = (d_quo > NW'(33'h0_7fff_ffff)) ? wmn_pkg::SAT_MAX : d_quo[31:0];
    end
    f_bad = d_side[1];
    f_val = prod_sat;
    if (map_mode == wmn_pkg::MODE_WEIGHT) begin
      if (d_side[0]) begin
        if (scale_factor == '0) begin
          f_bad = 1'b1;
        end
        f_val = scale_factor[31] ? wmn_pkg::SAT_MIN : wmn_pkg::SAT_MAX;
      end else begin
        f_val = quo_val;
      end
    end
    if (f_bad) begin
      f_val = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid;
    end
    if (en) begin
      noise_value <= f_val;
      bad_pixel   <= f_bad;
    end
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_pixel |-> noise_value == '0)
    else $error("bad item carries a nonzero noise value");

  a_rms_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && map_mode == wmn_pkg::MODE_RMS && !threshold_enable |-> !bad_pixel)
    else $error("RMS item flagged bad with threshold off");

  a_weight_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && map_mode == wmn_pkg::MODE_WEIGHT && !bad_pixel && !scale_factor[31]
    |-> !noise_value[31])
    else $error("weight item with positive factor came out negative");

endmodule
`default_nettype wire

// ----- rtl/core/wmn_sqrt.sv -----
`default_nettype none
// Integer square root, one root bit per stage, RW stages.
module wmn_sqrt #(
  parameter int RW   = 24,
  parameter int SB_W = 33
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [2*RW-1:0]   in_rad,
  input  wire logic [SB_W-1:0]   in_side,
  output logic                   out_valid,
  output logic [RW-1:0]          out_root,
  output logic [SB_W-1:0]        out_side
);

  logic            vld  [0:RW];
  logic [RW:0]     rem  [0:RW];
  logic [RW-1:0]   root [0:RW];
  logic [2*RW-1:0] rad  [0:RW];
  logic [SB_W-1:0] side [0:RW];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rad[0]  = in_rad;
  assign side[0] = in_side;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic          ge;

    always_comb begin
      rem_sh = {rem[k][RW-1:0], rad[k][2*RW-1 -: 2]};
      trial  = {root[k], 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        rem[k+1]  <= ge ? (RW+1)'(rem_sh - trial) : (RW+1)'(rem_sh);
        root[k+1] <= {root[k][RW-2:0], ge};
        rad[k+1]  <= {rad[k][2*RW-3:0], 2'b00};
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[RW];
  assign out_root  = root[RW];
  assign out_side  = side[RW];

endmodule
`default_nettype wire

// ----- rtl/core/wmn_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per stage, NW stages.
module wmn_div #(
  parameter int NW   = 48,
  parameter int DW   = 24,
  parameter int SB_W = 67
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [NW-1:0]   in_num,
  input  wire logic [DW-1:0]   in_den,
  input  wire logic [SB_W-1:0] in_side,
  output logic                 out_valid,
  output logic [NW-1:0]        out_quo,
  output logic [SB_W-1:0]      out_side
);

  logic            vld  [0:NW];
  logic [DW-1:0]   rem  [0:NW];
  logic [NW-1:0]   num  [0:NW];
  logic [NW-1:0]   quo  [0:NW];
  logic [DW-1:0]   den  [0:NW];
  logic [SB_W-1:0] side [0:NW];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign num[0]  = in_num;
  assign quo[0]  = '0;
  assign den[0]  = in_den;
  assign side[0] = in_side;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0] rem_sh;
    logic        ge;

    always_comb begin
      rem_sh = {rem[k], num[k][NW-1]};
      ge     = (rem_sh >= {1'b0, den[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        rem[k+1]  <= ge ? DW'(rem_sh - {1'b0, den[k]}) : DW'(rem_sh);
        num[k+1]  <= {num[k][NW-2:0], 1'b0};
        quo[k+1]  <= {quo[k][NW-2:0], ge};
        den[k+1]  <= den[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[NW];
  assign out_quo   = quo[NW];
  assign out_side  = side[NW];

endmodule
`default_nettype wire
